@@ rtl/lsp_pkg.sv @@
// Shared types and codes for the LIFO stack with positional insert.
// No dependencies; every other file of the block imports this package.
package lsp_pkg;

    localparam int DataW    = 32;
    localparam int PosW     = 5;
    localparam int DefDepth = 16;

    typedef logic signed [DataW-1:0] data_t;

    // Item actions
    localparam logic [1:0] ACT_PUSH    = 2'd0;
    localparam logic [1:0] ACT_POP     = 2'd1;
    localparam logic [1:0] ACT_DISPLAY = 2'd2;
    localparam logic [1:0] ACT_INSERT  = 2'd3;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_POS   = 2'd2;
    localparam logic [1:0] STAT_FULL  = 2'd3;

    // Command broadcast along the cell chain
    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_POP,
        CMD_ROTATE
    } cell_cmd_t;

endpackage

@@ rtl/lsp_cell.sv @@
// One storage cell of the stack chain: a word register fed by its neighbors.
// Depends on lsp_pkg.
module lsp_cell import lsp_pkg::*; #(
    parameter int Depth = DefDepth,
    parameter int Index = 0,
    localparam int IdxW = $clog2(Depth)
) (
    input  logic            aclk,
    input  cell_cmd_t       cmd,
    input  logic [IdxW-1:0] pos,
    input  logic [IdxW-1:0] last_idx,
    input  data_t           load_data,
    input  data_t           up_data,
    input  data_t           down_data,
    output data_t           q
);

    localparam logic [IdxW-1:0] MyIdx = IdxW'(Index);

    data_t q_reg;
    data_t q_next;

    always_comb begin
        q_next = q_reg;
        unique case (cmd)
            CMD_HOLD: begin
                q_next = q_reg;
            end
            CMD_INSERT: begin
                // cells above the slot hold, the slot loads, cells below sink
                if (MyIdx == pos) begin
                    q_next = load_data;
                end else if (MyIdx > pos) begin
                    q_next = up_data;
                end
            end
            CMD_POP: begin
                q_next = down_data;
            end
            CMD_ROTATE: begin
                // top word wraps to the bottom of the occupied region
                if (MyIdx == last_idx) begin
                    q_next = load_data;
                end else if (MyIdx < last_idx) begin
                    q_next = down_data;
                end
            end
            default: begin
                q_next = q_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

@@ rtl/lifo_stack_with_positional_insert_core.sv @@
// Top level of the LIFO stack with positional insert: control and cell chain.
// Depends on lsp_pkg and lsp_cell.
//
// Usage:
//   Input channel s_* carries one beat per item: action, value and position.
//   Result channel m_* returns status, data and last; every item yields one
//   beat with last high, except a display of a non-empty stack, which yields
//   one beat per stored word, top first, last high on the bottom word.
//   Storage is a chain of Depth cells, cell 0 being the top. Push and pop
//   move every cell by one neighbor; insert loads the slot and moves the cells below it.
//   Latency: but for a display of a non-empty stack, the result beat comes
//   in the cycle after the input beat. Flow: push, pop and insert items go
//   back to back as long as the receiver takes results. A display is taken,
//   then emits one word per step as the chain rotates the top word to the
//   bottom of the occupied cells (a step waits while the result register is
//   full); count steps restore the order. s_ready is low during a display.
//   Stall: a result waits in the output register; a new item is accepted only
//   when that register is empty or being drained in the same cycle.
//   Reset (aresetn low, synchronous): the stack is empty and no result is
//   pending. Cell contents are not cleared; only cells below count are read.
module lifo_stack_with_positional_insert_core import lsp_pkg::*; #(
    parameter int Depth = DefDepth
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_action,
    input  data_t            s_value,
    input  logic [PosW-1:0]  s_position,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_status,
    output data_t            m_data,
    output logic             m_last
);

    localparam int IdxW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);
    localparam int CmpW = (CntW > PosW) ? CntW : PosW;
    localparam logic [CntW-1:0] CntFull = CntW'(Depth);
    localparam logic [CntW-1:0] CntOne  = CntW'(1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DISP = 1'b1;

    logic            state_reg,  state_next;
    logic [CntW-1:0] count_reg,  count_next;
    logic [CntW-1:0] rem_reg,    rem_next;
    logic            m_valid_reg, m_valid_next;
    logic [1:0]      m_status_reg, m_status_next;
    data_t           m_data_reg, m_data_next;
    logic            m_last_reg, m_last_next;

    cell_cmd_t       cmd;
    logic [IdxW-1:0] cell_pos;
    logic [IdxW-1:0] last_idx;
    data_t           load_data;
    data_t           cell_q [Depth];

    logic            out_free;
    logic            in_fire;
    logic            is_full;
    logic            is_empty;
    logic [CmpW-1:0] pos_ext;
    logic [CmpW-1:0] cnt_ext;
    logic [CntW-1:0] cnt_minus1;

    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = (state_reg == S_IDLE) && out_free;
    assign in_fire    = s_valid && s_ready;
    assign is_full    = (count_reg == CntFull);
    assign is_empty   = (count_reg == '0);
    assign pos_ext    = CmpW'(s_position);
    assign cnt_ext    = CmpW'(count_reg);
    assign cnt_minus1 = count_reg - CntOne;
    assign last_idx   = cnt_minus1[IdxW-1:0];
    // during a display the top word wraps around; otherwise load the input
    assign load_data  = (state_reg == S_DISP) ? cell_q[0] : s_value;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        rem_next      = rem_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;
        cmd           = CMD_HOLD;
        cell_pos      = '0;

        if (in_fire) begin
            m_valid_next  = 1'b1;
            m_status_next = STAT_OK;
            m_data_next   = '0;
            m_last_next   = 1'b1;
            unique case (s_action)
                ACT_PUSH: begin
                    if (is_full) begin
                        m_status_next = STAT_FULL;
                    end else begin
                        cmd        = CMD_INSERT;
                        count_next = count_reg + CntOne;
                    end
                end
                ACT_POP: begin
                    if (is_empty) begin
                        m_status_next = STAT_EMPTY;
                    end else begin
                        cmd         = CMD_POP;
                        m_data_next = cell_q[0];
                        count_next  = cnt_minus1;
                    end
                end
                ACT_DISPLAY: begin
                    if (is_empty) begin
                        m_status_next = STAT_EMPTY;
                    end else begin
                        // no beat now; the words follow from the display state
                        m_valid_next = 1'b0;
                        state_next   = S_DISP;
                        rem_next     = count_reg;
                    end
                end
                ACT_INSERT: begin
                    priority if (pos_ext > cnt_ext) begin
                        m_status_next = STAT_POS;
                    end else if (is_full) begin
                        m_status_next = STAT_FULL;
                    end else begin
                        cmd        = CMD_INSERT;
                        cell_pos   = pos_ext[IdxW-1:0];
                        count_next = count_reg + CntOne;
                    end
                end
                default: begin
                    m_status_next = STAT_OK;
                end
            endcase
        end else if (state_reg == S_DISP && out_free) begin
            // emit the top word and rotate it to the bottom
            cmd           = CMD_ROTATE;
            m_valid_next  = 1'b1;
            m_status_next = STAT_OK;
            m_data_next   = cell_q[0];
            m_last_next   = (rem_reg == CntOne);
            rem_next      = rem_reg - CntOne;
            if (rem_reg == CntOne) begin
                state_next = S_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rem_reg     <= rem_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
    end

    // cell chain: cell 0 is the top of the stack
    for (genvar i = 0; i < Depth; i++) begin : g_cell
        data_t up_d;
        data_t down_d;
        if (i == 0) begin : g_top
            assign up_d = '0;
        end else begin : g_up
            assign up_d = cell_q[i-1];
        end
        if (i == Depth - 1) begin : g_bot
            assign down_d = '0;
        end else begin : g_down
            assign down_d = cell_q[i+1];
        end
        lsp_cell #(
            .Depth (Depth),
            .Index (i)
        ) u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .pos       (cell_pos),
            .last_idx  (last_idx),
            .load_data (load_data),
            .up_data   (up_d),
            .down_data (down_d),
            .q         (cell_q[i])
        );
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_data   = m_data_reg;
    assign m_last   = m_last_reg;

    // hold the fill level within the chain
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CntFull)
        else $error("stack count exceeds depth");

    // drop input acceptance while a display walks the chain
    a_no_accept_disp: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DISP |-> !s_ready)
        else $error("input accepted during display");

    // a display never runs with nothing left to emit
    a_disp_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DISP |-> rem_reg != '0)
        else $error("display active with zero words left");

    // the fill level holds while the chain rotates
    a_disp_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DISP |=> $stable(count_reg))
        else $error("count changed during display");

endmodule

@@ test/lifo_stack_with_positional_insert_core_test.sv @@
`timescale 1ns / 1ps
// Testbench for lifo_stack_with_positional_insert_core: directed and random item streams
// are checked beat by beat against a stack predictor kept inside the bench.
// Depends on lsp_pkg and the core RTL.
module lifo_stack_with_positional_insert_core_test;
    import lsp_pkg::*;

    localparam int    StackDepth = DefDepth;
    localparam int    IdleLimit  = 2000;
    localparam int    RandPhases = 8;
    localparam int    PhaseItems = 48;
    localparam data_t WordMax    = 32'sh7FFF_FFFF;
    localparam data_t WordMin    = 32'sh8000_0000;

    typedef struct {
        logic [1:0] status;
        data_t      data;
        logic       last;
    } result_beat_t;

    logic            aclk = 1'b0;
    logic            aresetn;
    logic            s_valid;
    logic            s_ready;
    logic [1:0]      s_action;
    data_t           s_value;
    logic [PosW-1:0] s_position;
    logic            m_valid;
    logic            m_ready;
    logic [1:0]      m_status;
    data_t           m_data;
    logic            m_last;

    // Predictor state: index 0 is the bottom word, stack_count-1 the top.
    data_t        stack_words [StackDepth];
    int           stack_count = 0;
    result_beat_t predicted_results [$];
    int           mismatch_count = 0;
    int           idle_cycles = 0;
    bit           no_idle = 1'b0;

    lifo_stack_with_positional_insert_core #(
        .Depth(StackDepth)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_action  (s_action),
        .s_value   (s_value),
        .s_position(s_position),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_status  (m_status),
        .m_data    (m_data),
        .m_last    (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Draw the idle cycles before one beat; burst stretches force zero.
    function automatic int draw_wait();
        return no_idle ? 0 : int'($urandom_range(0, 15));
    endfunction

    function automatic void owe_result(logic [1:0] status, data_t data, logic last);
        result_beat_t beat;
        beat.status = status;
        beat.data   = data;
        beat.last   = last;
        predicted_results.push_back(beat);
    endfunction

    // Advance the predicted stack by one accepted item and queue the beats it owes.
    function automatic void stack_predict(logic [1:0] action, data_t value,
                                          logic [PosW-1:0] position);
        int slot;
        case (action)
            ACT_PUSH: begin
                if (stack_count >= StackDepth) begin
                    owe_result(STAT_FULL, '0, 1'b1);
                end else begin
                    stack_words[stack_count] = value;
                    stack_count++;
                    owe_result(STAT_OK, '0, 1'b1);
                end
            end
            ACT_POP: begin
                if (stack_count == 0) begin
                    owe_result(STAT_EMPTY, '0, 1'b1);
                end else begin
                    stack_count--;
                    owe_result(STAT_OK, stack_words[stack_count], 1'b1);
                end
            end
            ACT_DISPLAY: begin
                if (stack_count == 0) begin
                    owe_result(STAT_EMPTY, '0, 1'b1);
                end else begin
                    // top first, last flag on the bottom word
                    for (int i = stack_count; i > 0; i--)
                        owe_result(STAT_OK, stack_words[i-1], i == 1);
                end
            end
            ACT_INSERT: begin
                // the position check takes priority over the full check
                if (int'(position) > stack_count) begin
                    owe_result(STAT_POS, '0, 1'b1);
                end else if (stack_count >= StackDepth) begin
                    owe_result(STAT_FULL, '0, 1'b1);
                end else begin
                    slot = stack_count - int'(position);
                    for (int i = stack_count; i > slot; i--)
                        stack_words[i] = stack_words[i-1];
                    stack_words[slot] = value;
                    stack_count++;
                    owe_result(STAT_OK, '0, 1'b1);
                end
            end
        endcase
    endfunction

    // Send one item beat; valid stays high across back-to-back beats.
    task automatic send_item(input logic [1:0] action, input data_t value,
                             input logic [PosW-1:0] position);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_action   <= action;
        s_value    <= value;
        s_position <= position;
        do @(posedge aclk); while (s_ready !== 1'b1);
        stack_predict(action, value, position);
    endtask

    // Drop valid and hold off until every owed beat has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (predicted_results.size() != 0);
    endtask

    function automatic void check_beat();
        result_beat_t want;
        if (predicted_results.size() == 0) begin
            $error("unexpected result beat: status %0d data %0d last %0d",
                   m_status, m_data, m_last);
            mismatch_count++;
            return;
        end
        want = predicted_results.pop_front();
        if (m_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_status);
            mismatch_count++;
        end
        if (m_data !== want.data) begin
            $error("data: expected %0d, got %0d", want.data, m_data);
            mismatch_count++;
        end
        if (m_last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, m_last);
            mismatch_count++;
        end
    endfunction

    // Result side: stall a random number of cycles before each beat, then take it.
    initial begin : result_sink
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            check_beat();
        end
    end

    // Watchdog: end the run when no beat moves on either channel for too long.
    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IdleLimit) begin
                $display("FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Empty stack: pop, display and out-of-range inserts all report errors.
    task automatic test_empty_stack();
        send_item(ACT_POP, '0, '0);
        send_item(ACT_DISPLAY, '0, '0);
        send_item(ACT_INSERT, 32'sd5, 5'd1);
        send_item(ACT_INSERT, -32'sd5, 5'd31);
    endtask

    // Word extremes and alternating bit patterns through push, display and pop.
    task automatic test_push_pop_extremes();
        send_item(ACT_PUSH, WordMax, '0);
        send_item(ACT_PUSH, WordMin, '0);
        send_item(ACT_PUSH, 32'sh5555_5555, 5'd31);
        send_item(ACT_PUSH, 32'shAAAA_AAAA, '0);
        send_item(ACT_DISPLAY, '0, '0);
        send_item(ACT_POP, '0, '0);
    endtask

    // Insert at top, bottom and middle, then one and far beyond the count.
    task automatic test_insert_positions();
        send_item(ACT_INSERT, 32'sd100, 5'd0);
        send_item(ACT_INSERT, -32'sd1, PosW'(stack_count));
        send_item(ACT_INSERT, 32'sd0, 5'd2);
        send_item(ACT_INSERT, 32'sd7, PosW'(stack_count + 1));
        send_item(ACT_INSERT, 32'sd8, 5'd16);
        send_item(ACT_DISPLAY, '0, '0);
    endtask

    // Full stack: push and insert refused, beyond-count insert still reports position.
    task automatic test_full_stack();
        while (stack_count < StackDepth)
            send_item(ACT_PUSH, data_t'($urandom), '0);
        send_item(ACT_PUSH, 32'sd1, '0);
        send_item(ACT_INSERT, 32'sd2, 5'd0);
        send_item(ACT_INSERT, 32'sd3, 5'd16);
        send_item(ACT_INSERT, 32'sd4, 5'd17);
        send_item(ACT_DISPLAY, '0, '0);
    endtask

    // Random mix: phases alternate between draining and filling the stack, so both
    // ends are reached often; two phases run without idling, and the sender
    // holds off after each phase until every beat is back.
    task automatic test_random_mix();
        int r;
        logic [1:0] action;
        data_t value;
        logic [PosW-1:0] position;
        bit filling;
        for (int phase = 0; phase < RandPhases; phase++) begin
            filling = phase[0];
            no_idle = (phase == 2) || (phase == 5);
            for (int n = 0; n < PhaseItems; n++) begin
                r = $urandom_range(0, 99);
                if (filling)
                    action = r < 40 ? ACT_PUSH : r < 70 ? ACT_INSERT :
                             r < 88 ? ACT_POP : ACT_DISPLAY;
                else
                    action = r < 20 ? ACT_PUSH : r < 35 ? ACT_INSERT :
                             r < 85 ? ACT_POP : ACT_DISPLAY;
                case ($urandom_range(0, 7))
                    0:       value = WordMax;
                    1:       value = WordMin;
                    2:       value = '0;
                    3:       value = -32'sd1;
                    default: value = data_t'($urandom);
                endcase
                if ($urandom_range(0, 9) == 0)
                    position = PosW'($urandom_range(0, 31));
                else
                    position = PosW'($urandom_range(0, stack_count));
                send_item(action, value, position);
            end
            wait_drained();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        aresetn    <= 1'b0;
        s_valid    <= 1'b0;
        s_action   <= ACT_PUSH;
        s_value    <= '0;
        s_position <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_stack();
        test_push_pop_extremes();
        test_insert_positions();
        wait_drained();
        test_full_stack();
        test_random_mix();

        // settle: a display may still be rotating after its last beat is owed
        wait_drained();
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
